FILE: hw/rtl/trsr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// trsr_pkg
// Shared sizes, codes and controller/datapath interface types for the
// trie shortest-root replacer.
// ----------------------------------------------------------------------------
package trsr_pkg;

	localparam int NODE_COUNT    = 1024;
	localparam int ALPHABET_SIZE = 26;

	localparam int NODE_W = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
	localparam int FREE_W = NODE_W + 1;
	localparam int LET_W  = (ALPHABET_SIZE > 1) ? $clog2(ALPHABET_SIZE) : 1;
	localparam int SLOTS  = NODE_COUNT * ALPHABET_SIZE;
	localparam int SLOT_W = $clog2(SLOTS);

	localparam logic [7:0] LETTER_BASE = 8'h61;
	localparam logic [7:0] SPACE_CHAR  = 8'h20;

	localparam logic [1:0] ACT_DICT_LETTER = 2'd0;
	localparam logic [1:0] ACT_DICT_END    = 2'd1;
	localparam logic [1:0] ACT_SENTENCE    = 2'd2;

	localparam logic [1:0] STATUS_OK       = 2'd0;
	localparam logic [1:0] STATUS_FULL     = 2'd1;
	localparam logic [1:0] STATUS_BAD_CHAR = 2'd2;

	typedef enum logic [1:0] {
		MODE_MATCH = 2'd0,
		MODE_PASS  = 2'd1,
		MODE_DROP  = 2'd2
	} word_mode_t;

	typedef struct packed {
		logic clear;    // step the clearing pass
		logic capture;  // take an input beat and launch the memory reads
		logic eval;     // resolve the read data and load the result
	} dp_cmd_t;

	typedef struct packed {
		logic clear_last;
	} dp_stat_t;

endpackage
`default_nettype wire

FILE: hw/rtl/trsr_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// trsr_ctrl
// Sequencer: clearing pass after reset, then capture / evaluate per beat,
// and the valid flag of the result register.
// ----------------------------------------------------------------------------
module trsr_ctrl import trsr_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  wire logic     out_ready,
	output dp_cmd_t       cmd,
	input  wire dp_stat_t stat
);

	typedef enum logic [2:0] {
		ST_CLEAR = 3'b001,
		ST_IDLE  = 3'b010,
		ST_EVAL  = 3'b100
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   accept;

	assign in_ready  = (state_q == ST_IDLE) && (!out_valid_q || out_ready);
	assign accept    = in_valid && in_ready;
	assign out_valid = out_valid_q;

	assign cmd.clear   = (state_q == ST_CLEAR);
	assign cmd.capture = accept;
	assign cmd.eval    = (state_q == ST_EVAL);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (stat.clear_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (accept) state_d = ST_EVAL;
			end
			ST_EVAL: begin
				state_d = ST_IDLE;
			end
			default: state_d = ST_CLEAR;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			// eval only runs after the previous beat has left
			if (state_q == ST_EVAL) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

FILE: hw/rtl/trsr_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// trsr_dp
// Datapath: child table and root-mark memories, insert and match cursors,
// node allocator, word mode and the result register.
// ----------------------------------------------------------------------------
module trsr_dp import trsr_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire dp_cmd_t     cmd,
	output dp_stat_t         stat,
	input  wire logic [1:0]  action,
	input  wire logic [7:0]  char_in,
	output logic             keep,
	output logic [7:0]       char_out,
	output logic [1:0]       status
);

	logic [NODE_W-1:0] child_mem [SLOTS];
	logic              flag_mem  [NODE_COUNT];

	logic [SLOT_W-1:0] clr_cnt_q;
	logic [NODE_W-1:0] insert_cur_q;
	logic [NODE_W-1:0] match_cur_q;
	logic [FREE_W-1:0] next_free_q;
	word_mode_t        mode_q;

	logic [1:0]        act_q;
	logic [7:0]        chr_q;
	logic              letter_q;
	logic [SLOT_W-1:0] slot_q;
	logic [NODE_W-1:0] child_rd_q;
	logic              flag_rd_q;
	logic              keep_q;
	logic [1:0]        status_q;

	logic              is_letter;
	logic [LET_W-1:0]  letter_idx;
	logic [NODE_W-1:0] walk_cur;
	logic [SLOT_W-1:0] slot_addr;
	logic              child_we;
	logic [SLOT_W-1:0] child_wa;
	logic [NODE_W-1:0] child_wd;
	logic              flag_we;
	logic [NODE_W-1:0] flag_wa;
	logic              flag_wd;
	logic              clr_flags;
	logic              alloc;
	logic              keep_d;
	logic [1:0]        status_d;

	assign stat.clear_last = (clr_cnt_q == SLOT_W'(SLOTS - 1));
	assign clr_flags       = cmd.clear && (clr_cnt_q < SLOT_W'(NODE_COUNT));

	assign is_letter  = (char_in >= LETTER_BASE) &&
	                    ({1'b0, char_in} < 9'(int'(LETTER_BASE) + ALPHABET_SIZE));
	assign letter_idx = LET_W'(char_in - LETTER_BASE);
	assign walk_cur   = (action == ACT_SENTENCE) ? match_cur_q : insert_cur_q;
	// non-letters park the read at slot zero; their data is never used
	assign slot_addr  = is_letter ?
	                    SLOT_W'(SLOT_W'(walk_cur) * SLOT_W'(ALPHABET_SIZE)
	                            + SLOT_W'(letter_idx)) : '0;

	assign alloc = cmd.eval && (act_q == ACT_DICT_LETTER) && letter_q &&
	               (child_rd_q == '0) && (next_free_q < FREE_W'(NODE_COUNT));

	always_comb begin
		child_we = cmd.clear || alloc;
		child_wa = cmd.clear ? clr_cnt_q : slot_q;
		child_wd = cmd.clear ? '0 : next_free_q[NODE_W-1:0];
		flag_we  = clr_flags || (cmd.eval && (act_q == ACT_DICT_END));
		flag_wa  = clr_flags ? clr_cnt_q[NODE_W-1:0] : insert_cur_q;
		flag_wd  = !clr_flags;
	end

	always_comb begin
		keep_d   = 1'b0;
		status_d = STATUS_OK;
		unique case (act_q)
			ACT_DICT_LETTER: begin
				if (!letter_q) begin
					status_d = STATUS_BAD_CHAR;
				end else if (child_rd_q == '0 &&
				             next_free_q >= FREE_W'(NODE_COUNT)) begin
					status_d = STATUS_FULL;
				end
			end
			ACT_SENTENCE: begin
				if (chr_q == SPACE_CHAR) begin
					keep_d = 1'b1;
				end else if (mode_q == MODE_DROP) begin
					keep_d = 1'b0;
				end else if (mode_q == MODE_PASS) begin
					keep_d = 1'b1;
				end else begin
					keep_d = !(flag_rd_q && match_cur_q != '0);
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (child_we) child_mem[child_wa] <= child_wd;
		if (cmd.capture) child_rd_q <= child_mem[slot_addr];
	end

	always_ff @(posedge clk) begin
		if (flag_we) flag_mem[flag_wa] <= flag_wd;
		if (cmd.capture) flag_rd_q <= flag_mem[match_cur_q];
	end

	// beat capture and result payload
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			act_q    <= action;
			chr_q    <= char_in;
			letter_q <= is_letter;
			slot_q   <= slot_addr;
		end
		if (cmd.eval) begin
			keep_q   <= keep_d;
			status_q <= status_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q    <= '0;
			insert_cur_q <= '0;
			match_cur_q  <= '0;
			next_free_q  <= FREE_W'(1);
			mode_q       <= MODE_MATCH;
		end else begin
			if (cmd.clear && !stat.clear_last) clr_cnt_q <= clr_cnt_q + 1'b1;
			if (cmd.eval) begin
				unique case (act_q)
					ACT_DICT_LETTER: begin
						if (letter_q && child_rd_q != '0) begin
							insert_cur_q <= child_rd_q;
						end else if (alloc) begin
							insert_cur_q <= next_free_q[NODE_W-1:0];
							next_free_q  <= next_free_q + 1'b1;
						end
					end
					ACT_DICT_END: begin
						insert_cur_q <= '0;
					end
					ACT_SENTENCE: begin
						if (chr_q == SPACE_CHAR) begin
							match_cur_q <= '0;
							mode_q      <= MODE_MATCH;
						end else if (mode_q == MODE_MATCH) begin
							if (flag_rd_q) begin
								mode_q <= (match_cur_q != '0) ? MODE_DROP : MODE_PASS;
							end else if (letter_q && child_rd_q != '0) begin
								match_cur_q <= child_rd_q;
							end else begin
								mode_q <= MODE_PASS;
							end
						end
					end
					default: ;
				endcase
			end
		end
	end

	assign keep     = keep_q;
	assign char_out = chr_q;
	assign status   = status_q;

endmodule
`default_nettype wire

FILE: hw/rtl/trie_shortest_root_replacer_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// trie_shortest_root_replacer_core
// Builds a trie of dictionary roots and shortens sentence words to the
// shortest root they start with.
// ----------------------------------------------------------------------------
// channel | handshake            | payload
// --------+----------------------+-------------------------------
// in      | in_valid / in_ready  | action[1:0], char_in[7:0]
// out     | out_valid / out_ready| keep, char_out[7:0], status[1:0]
//
// For each beat, the accept cycle launches the child-table and root-mark
// reads, and the next cycle resolves the registered read data, updates
// the cursors and loads the result register.
// After reset a clearing pass writes the child table one slot a cycle,
// all NODE_COUNT * ALPHABET_SIZE slots (26624), with in_ready low throughout.
// A new beat is taken only while the result register is empty or draining.
// ----------------------------------------------------------------------------
module trie_shortest_root_replacer_core import trsr_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [1:0] action,
	input  wire logic [7:0] char_in,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic            keep,
	output logic [7:0]      char_out,
	output logic [1:0]      status
);

	dp_cmd_t  cmd;
	dp_stat_t stat;

	trsr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.stat      (stat)
	);

	trsr_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.stat     (stat),
		.action   (action),
		.char_in  (char_in),
		.keep     (keep),
		.char_out (char_out),
		.status   (status)
	);

endmodule
`default_nettype wire
